// ===== rtl/b2b_pkg.sv =====
// ----------------------------------------------------------------------------
// b2b_pkg
// Shared constants, types and tables for the BLAKE2b-256 engine.
// ----------------------------------------------------------------------------
package b2b_pkg;

   localparam int WordWidth = 64;
   localparam int Rounds    = 12;

   typedef logic [63:0] word_type;
   typedef logic [3:0]  idx_type;

   localparam word_type ParamWord = 64'h0000_0000_0101_0020;

   // initialization vector
   function automatic word_type iv_word(input logic [2:0] i);
      word_type r;
      unique case (i)
         3'd0: r = 64'h6a09e667f3bcc908;
         3'd1: r = 64'hbb67ae8584caa73b;
         3'd2: r = 64'h3c6ef372fe94f82b;
         3'd3: r = 64'ha54ff53a5f1d36f1;
         3'd4: r = 64'h510e527fade682d1;
         3'd5: r = 64'h9b05688c2b3e6c1f;
         3'd6: r = 64'h1f83d9abfb41bd6b;
         3'd7: r = 64'h5be0cd19137e2179;
         default: r = '0;
      endcase
      return r;
   endfunction

   // message schedule: row, position -> message word index
   function automatic idx_type sigma(input logic [3:0] row, input logic [3:0] pos);
      logic [63:0] r;
      unique case (row)
         4'd0: r = 64'hfedcba9876543210;
         4'd1: r = 64'h357b20c16df984ae;
         4'd2: r = 64'h491763eadf250c8b;
         4'd3: r = 64'h8f04a562ebcd1397;
         4'd4: r = 64'hd386cb1efa427509;
         4'd5: r = 64'h91ef57d438b0a6c2;
         4'd6: r = 64'hb8293670a4def15c;
         4'd7: r = 64'ha2684f05931ce7bd;
         4'd8: r = 64'h5a417d2c803b9ef6;
         4'd9: r = 64'h0dc3e9bf5167482a;
         default: r = '0;
      endcase
      return r[pos*4 +: 4];
   endfunction

   // indexes of a, b, c, d for each of the eight mixes
   function automatic logic [15:0] mix_idx(input logic [2:0] g);
      logic [15:0] r;
      unique case (g)
         3'd0: r = 16'hc840;
         3'd1: r = 16'hd951;
         3'd2: r = 16'hea62;
         3'd3: r = 16'hfb73;
         3'd4: r = 16'hfa50;
         3'd5: r = 16'hcb61;
         3'd6: r = 16'hd872;
         3'd7: r = 16'he943;
         default: r = '0;
      endcase
      return r;
   endfunction

   typedef struct packed {
      logic start;
      logic last;
   } cmd_type;

endpackage

// ===== rtl/b2b_if.sv =====
// ----------------------------------------------------------------------------
// b2b_req_if / b2b_rsp_if
// Valid/ready channels for requests and digest words.
// ----------------------------------------------------------------------------
interface b2b_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] message_word;
   logic [3:0]  byte_count;
   logic        final_item;
   modport source (output valid, message_word, byte_count, final_item, input ready);
   modport sink   (input valid, message_word, byte_count, final_item, output ready);
endinterface

interface b2b_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] digest_word;
   logic [1:0]  word_index;
   logic        last_word;
   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== rtl/b2b_compress.sv =====
// ----------------------------------------------------------------------------
// b2b_compress
// Compression function: one quarter G step (add, xor, rotate) per cycle on a
// single shared adder path, 8 mixes per round, 12 rounds.
// ----------------------------------------------------------------------------
module b2b_compress
   import b2b_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cmd_type         cmd,
   input  word_type        cv_i   [8],
   input  word_type        msg_i  [16],
   input  word_type        count_i,
   output logic            done,
   output word_type        cv_o   [8]
);

   word_type    v_ff [16];
   word_type    v_in [16];
   logic        busy_ff, busy_in;
   logic [3:0]  round_ff, round_in;
   logic [2:0]  mix_ff, mix_in;
   logic [1:0]  step_ff, step_in;
   logic [3:0]  row;
   logic [15:0] ids;
   idx_type     ia, ib, ic, id, mi;
   word_type    sa, sb, sc, sd, mw, sum, xr;
   logic        last_step;

   assign row = (round_ff >= 4'd10) ? round_ff - 4'd10 : round_ff;
   assign ids = mix_idx(mix_ff);
   assign ia  = ids[3:0];
   assign ib  = ids[7:4];
   assign ic  = ids[11:8];
   assign id  = ids[15:12];
   assign mi  = sigma(row, {mix_ff, step_ff[1]});
   assign sa  = v_ff[ia];
   assign sb  = v_ff[ib];
   assign sc  = v_ff[ic];
   assign sd  = v_ff[id];
   assign mw  = msg_i[mi];
   assign last_step = (step_ff == 2'd3) && (mix_ff == 3'd7)
                      && (round_ff == 4'(Rounds - 1));

   // shared quarter-G datapath
   always_comb begin
      v_in     = v_ff;
      busy_in  = busy_ff;
      round_in = round_ff;
      mix_in   = mix_ff;
      step_in  = step_ff;
      sum      = '0;
      xr       = '0;
      if (cmd.start) begin
         for (int i = 0; i < 8; i++) begin
            v_in[i]   = cv_i[i];
            v_in[i+8] = iv_word(3'(i));
         end
         v_in[12] = v_in[12] ^ count_i;
         if (cmd.last) v_in[14] = ~v_in[14];
         busy_in  = 1'b1;
         round_in = '0;
         mix_in   = '0;
         step_in  = '0;
      end else if (busy_ff) begin
         unique case (step_ff)
            2'd0, 2'd2: begin
               sum    = sa + sb + mw;
               xr     = sd ^ sum;
               v_in[ia] = sum;
               v_in[id] = (step_ff == 2'd0) ? {xr[31:0], xr[63:32]}
                                            : {xr[15:0], xr[63:16]};
            end
            default: begin
               sum    = sc + sd;
               xr     = sb ^ sum;
               v_in[ic] = sum;
               v_in[ib] = (step_ff == 2'd1) ? {xr[23:0], xr[63:24]}
                                            : {xr[62:0], xr[63]};
            end
         endcase
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd3) begin
            mix_in = mix_ff + 3'd1;
            if (mix_ff == 3'd7) round_in = round_ff + 4'd1;
         end
         if (last_step) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      v_ff     <= v_in;
      round_ff <= round_in;
      mix_ff   <= mix_in;
      step_ff  <= step_in;
      if (reset) busy_ff <= 1'b0;
      else       busy_ff <= busy_in;
   end

   assign done = busy_ff && last_step;

   always_comb begin
      for (int i = 0; i < 8; i++) cv_o[i] = cv_i[i] ^ v_in[i] ^ v_in[i+8];
   end

endmodule

// ===== rtl/blake2b_256_hash_engine_unit.sv =====
// ----------------------------------------------------------------------------
// blake2b_256_hash_engine_unit
// Unkeyed BLAKE2b-256 over a stream of little-endian 64-bit words.
// ----------------------------------------------------------------------------
// Usage: the req channel takes one message word per request, byte_count valid
// bytes (8 unless final_item). A request is accepted in S_IDLE and appended
// to the block buffer in the following S_PRE state, after which req_ready is
// back when no compression runs. A word arriving after a full 16-word block
// first runs that compression, started from S_PRE (12 rounds x 8 mixes x 4
// quarter steps on one shared adder/rotate path), then is appended.
// A final request appends its bytes and starts the last compression in the
// same cycle; the first digest word is valid in S_OUT once that compression
// is done, a pending block being compressed first. Four digest words follow on
// rsp, word_index 0..3, last_word on the fourth, one per cycle while rsp_ready
// is high. The rsp side holds its word while stalled; req_ready stays low
// until all four are taken, then the engine is back in its reset state.
// Reset (synchronous, active high) loads the IV chain value, clears the
// buffer, byte counter and pending flag, drops rsp valid and raises req ready.
// ----------------------------------------------------------------------------
module blake2b_256_hash_engine_unit
   import b2b_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   b2b_req_if.sink     req,
   b2b_rsp_if.source   rsp
);

   typedef enum logic [2:0] {S_IDLE, S_PRE, S_MID, S_FIN, S_OUT} state_type;

   state_type   state_ff;
   word_type    cv_ff  [8];
   word_type    buf_ff [16];
   word_type    bytes_ff;
   logic [4:0]  fill_ff;
   logic        pend_ff;
   word_type    hold_word_ff;
   logic [3:0]  hold_cnt_ff;
   logic        hold_fin_ff;
   logic [1:0]  out_idx_ff;
   cmd_type     cmd;
   logic        done;
   word_type    cv_new [8];
   logic [3:0]  cnt;
   word_type    masked;
   word_type    count_w;

   // the last block counts the bytes of the word appended with it
   assign count_w = bytes_ff + (cmd.last ? 64'(cnt) : 64'd0);

   b2b_compress u_comp (
      .clock(clock), .reset(reset), .cmd(cmd), .cv_i(cv_ff), .msg_i(buf_ff),
      .count_i(count_w), .done(done), .cv_o(cv_new)
   );

   assign req.ready       = (state_ff == S_IDLE);
   assign rsp.valid       = (state_ff == S_OUT);
   assign rsp.digest_word = cv_ff[out_idx_ff];
   assign rsp.word_index  = out_idx_ff;
   assign rsp.last_word   = (out_idx_ff == 2'd3);

   // effective byte count and masked word of the held request
   always_comb begin
      cnt = (!hold_fin_ff || hold_cnt_ff > 4'd8) ? 4'd8 : hold_cnt_ff;
      masked = hold_word_ff;
      for (int b = 0; b < 8; b++)
         if (4'(b) >= cnt) masked[b*8 +: 8] = 8'h00;
   end

   always_comb begin
      cmd.start = 1'b0;
      cmd.last  = 1'b0;
      if (state_ff == S_PRE && pend_ff && cnt != 4'd0) cmd.start = 1'b1;
      if (state_ff == S_PRE && !(pend_ff && cnt != 4'd0) && hold_fin_ff) begin
         cmd.start = 1'b1;
         cmd.last  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         bytes_ff   <= '0;
         fill_ff    <= '0;
         pend_ff    <= 1'b0;
         out_idx_ff <= '0;
         for (int i = 0; i < 8; i++)
            cv_ff[i] <= (i == 0) ? iv_word(3'(i)) ^ ParamWord : iv_word(3'(i));
         for (int i = 0; i < 16; i++) buf_ff[i] <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (req.valid) begin
               hold_word_ff <= req.message_word;
               hold_cnt_ff  <= req.byte_count;
               hold_fin_ff  <= req.final_item;
               state_ff     <= S_PRE;
            end
            S_PRE: begin
               if (pend_ff && cnt != 4'd0) begin
                  state_ff <= S_MID;   // compress full block, then append
               end else begin
                  if (cnt != 4'd0) begin
                     buf_ff[fill_ff[3:0]] <= masked;
                     fill_ff  <= fill_ff + 5'd1;
                     bytes_ff <= bytes_ff + 64'(cnt);
                     pend_ff  <= (fill_ff == 5'd15);
                  end
                  state_ff <= hold_fin_ff ? S_FIN : S_IDLE;
               end
            end
            S_MID, S_FIN: if (done) begin
               for (int i = 0; i < 8; i++) cv_ff[i] <= cv_new[i];
               for (int i = 0; i < 16; i++) buf_ff[i] <= '0;
               fill_ff <= '0;
               pend_ff <= 1'b0;
               // a mid-message compression returns to append the held word
               state_ff <= (state_ff == S_MID) ? S_PRE : S_OUT;
               out_idx_ff <= '0;
            end
            S_OUT: if (rsp.ready) begin
               out_idx_ff <= out_idx_ff + 2'd1;
               if (out_idx_ff == 2'd3) begin
                  state_ff <= S_IDLE;
                  bytes_ff <= '0;
                  for (int i = 0; i < 8; i++)
                     cv_ff[i] <= (i == 0) ? iv_word(3'(i)) ^ ParamWord
                                          : iv_word(3'(i));
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/b2b_checker.sv =====
// ----------------------------------------------------------------------------
// b2b_checker
// Port-level checks on the digest channel of the hash engine.
// ----------------------------------------------------------------------------
module b2b_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_word_index,
   input logic       rsp_last_word
);

   // last_word flags exactly the fourth word
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_word_index == 2'd3)))
      else $error("last_word mismatch");

   // no new request taken while digest words are pending
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request accepted during output");

   // word index advances by one after each taken non-final word
   a_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_word) |=>
         (rsp_valid && rsp_word_index == $past(rsp_word_index) + 2'd1))
      else $error("digest word order");

   // stalled output keeps valid and its word index
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_word_index)))
      else $error("stalled output changed");

endmodule

bind blake2b_256_hash_engine_unit b2b_checker u_b2b_checker (
   .clock(clock), .reset(reset), .req_ready(req.ready), .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready), .rsp_word_index(rsp.word_index),
   .rsp_last_word(rsp.last_word)
);

// ===== bench/b2b_tb_if.sv =====
// ----------------------------------------------------------------------------
// b2b_tb_if
// Bench-side note: the channel interfaces come from the RTL file b2b_if.sv.
// This file only holds small shared bench types for message and digest words.
// ----------------------------------------------------------------------------
package b2b_tb_pkg;

   // one message word as the bench sends it
   typedef struct {
      logic [63:0] message_word;
      logic [3:0]  byte_count;
      logic        final_item;
   } msg_word_type;

   // one digest word as the bench expects it
   typedef struct {
      logic [63:0] digest_word;
      logic [1:0]  word_index;
      logic        last_word;
   } digest_type;

endpackage

// ===== bench/blake2b_256_hash_engine_unit_tb.sv =====
// ----------------------------------------------------------------------------
// blake2b_256_hash_engine_unit_tb
// Sends message words to the BLAKE2b-256 engine and checks every digest word
// against a digest computed inside the bench, under random stalls and gaps.
// ----------------------------------------------------------------------------
module blake2b_256_hash_engine_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import b2b_pkg::*;
   import b2b_tb_pkg::*;

   localparam int TimeoutCycles = 3_000_000;

   logic clock;
   logic reset;

   b2b_req_if req ();
   b2b_rsp_if rsp ();

   blake2b_256_hash_engine_unit uut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   // hash state copy
   logic [63:0] chain_h [8];
   logic [63:0] blk_m [16];
   logic [63:0] byte_total;
   int          blk_words;
   bit          blk_full;

   digest_type  digest_queue [$];
   int          mismatches;
   int          checked;
   int          sent;
   int          messages;
   bit          hold_long;
   longint      cycle_count;

   logic [63:0] ivv [8] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
      64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
      64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

   int perm [10][16] = '{
      '{ 0, 1, 2, 3, 4, 5, 6, 7, 8, 9,10,11,12,13,14,15},
      '{14,10, 4, 8, 9,15,13, 6, 1,12, 0, 2,11, 7, 5, 3},
      '{11, 8,12, 0, 5, 2,15,13,10,14, 3, 6, 7, 1, 9, 4},
      '{ 7, 9, 3, 1,13,12,11,14, 2, 6, 5,10, 4, 0,15, 8},
      '{ 9, 0, 5, 7, 2, 4,10,15,14, 1,11,12, 6, 8, 3,13},
      '{ 2,12, 6,10, 0,11, 8, 3, 4,13, 7, 5,15,14, 1, 9},
      '{12, 5, 1,15,14,13, 4,10, 0, 7, 6, 3, 9, 2, 8,11},
      '{13,11, 7,14,12, 1, 3, 9, 5, 0,15, 4, 8, 6, 2,10},
      '{ 6,15,14, 9,11, 3, 0, 8,12, 2,13, 7, 1, 4,10, 5},
      '{10, 2, 8, 4, 7, 6, 1, 5,15,11, 9,14, 3,12,13, 0}};

   function automatic logic [63:0] rotr(logic [63:0] w, int s);
      return (w >> s) | (w << (64 - s));
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > TimeoutCycles) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic hash_restart();
      for (int i = 0; i < 8; i++) chain_h[i] = ivv[i];
      chain_h[0] ^= ParamWord;
      for (int i = 0; i < 16; i++) blk_m[i] = '0;
      byte_total = '0;
      blk_words = 0;
      blk_full = 1'b0;
   endtask

   // one BLAKE2b compression of the held block
   task automatic compress_block(bit is_last);
      logic [63:0] v [16];
      int a [8] = '{0, 1, 2, 3, 0, 1, 2, 3};
      int b [8] = '{4, 5, 6, 7, 5, 6, 7, 4};
      int c [8] = '{8, 9, 10, 11, 10, 11, 8, 9};
      int d [8] = '{12, 13, 14, 15, 15, 12, 13, 14};
      for (int i = 0; i < 8; i++) begin
         v[i] = chain_h[i];
         v[i + 8] = ivv[i];
      end
      v[12] ^= byte_total;
      if (is_last) v[14] = ~v[14];
      for (int r = 0; r < 12; r++) begin
         for (int g = 0; g < 8; g++) begin
            v[a[g]] = v[a[g]] + v[b[g]] + blk_m[perm[r % 10][2 * g]];
            v[d[g]] = rotr(v[d[g]] ^ v[a[g]], 32);
            v[c[g]] = v[c[g]] + v[d[g]];
            v[b[g]] = rotr(v[b[g]] ^ v[c[g]], 24);
            v[a[g]] = v[a[g]] + v[b[g]] + blk_m[perm[r % 10][2 * g + 1]];
            v[d[g]] = rotr(v[d[g]] ^ v[a[g]], 16);
            v[c[g]] = v[c[g]] + v[d[g]];
            v[b[g]] = rotr(v[b[g]] ^ v[c[g]], 63);
         end
      end
      for (int i = 0; i < 8; i++) chain_h[i] ^= v[i] ^ v[i + 8];
      for (int i = 0; i < 16; i++) blk_m[i] = '0;
      blk_words = 0;
      blk_full = 1'b0;
   endtask

   // absorb one accepted request; queue the digest on a final word
   task automatic absorb_word(msg_word_type w);
      int          n;
      logic [63:0] data;
      digest_type  e;
      n = w.byte_count;
      data = w.message_word;
      if (!w.final_item || n > 8) n = 8;
      if (n > 0) begin
         if (blk_full || blk_words >= 16) compress_block(1'b0);
         if (n < 8) data &= (64'd1 << (8 * n)) - 64'd1;
         blk_m[blk_words % 16] = data;
         blk_words++;
         byte_total += 64'(n);
         blk_full = (blk_words == 16);
      end
      if (w.final_item) begin
         compress_block(1'b1);
         for (int k = 0; k < 4; k++) begin
            e.digest_word = chain_h[k];
            e.word_index = 2'(k);
            e.last_word = (k == 3);
            digest_queue.push_back(e);
         end
         hash_restart();
         messages++;
      end
   endtask

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 40) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // send one request, waiting for the handshake
   task automatic send_word(logic [63:0] data, int cnt, bit fin);
      msg_word_type w;
      int gap;
      gap = gap_len();
      repeat (gap) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      w.message_word = data;
      w.byte_count = 4'(cnt);
      w.final_item = fin;
      req.valid <= 1'b1;
      req.message_word <= data;
      req.byte_count <= 4'(cnt);
      req.final_item <= fin;
      do @(posedge clock); while (!req.ready);
      absorb_word(w);
      sent++;
      @(negedge clock);
   endtask

   function automatic logic [63:0] rand_word();
      return {$urandom(), $urandom()};
   endfunction

   // send a message of nfull whole words, then a final word of tail bytes
   task automatic send_message(int nfull, int tail);
      for (int i = 0; i < nfull; i++)
         send_word(rand_word(), (i % 3 == 0) ? $urandom_range(0, 15) : 8, 1'b0);
      send_word(rand_word(), tail, 1'b1);
   endtask

   // response ready pattern and digest check
   initial begin
      rsp.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_long) rsp.ready <= 1'b0;
         else if ($urandom_range(0, 99) < 8) begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(5, 40)) @(negedge clock);
            rsp.ready <= 1'b1;
         end else rsp.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   always @(posedge clock) begin
      digest_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (digest_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected digest word %h", rsp.digest_word);
         end else begin
            e = digest_queue.pop_front();
            checked++;
            if (e.digest_word !== rsp.digest_word || e.word_index !== rsp.word_index
                || e.last_word !== rsp.last_word) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("digest mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
                     e.digest_word, e.word_index, e.last_word,
                     rsp.digest_word, rsp.word_index, rsp.last_word);
            end
         end
      end
   end

   // directed: empty message, short tails, exact block, oversized counts
   task automatic test_directed();
      send_word(64'h0, 0, 1'b1);
      send_word(64'h0000_0000_0063_6261, 3, 1'b1);
      send_word(64'hffff_ffff_ffff_ffff, 8, 1'b1);
      send_word(64'hffff_ffff_ffff_ffff, 15, 1'b1);
      send_word(64'hffff_ffff_ffff_ffff, 9, 1'b1);
      send_message(15, 8);
      send_message(16, 0);
      send_message(16, 1);
      send_message(1, 7);
   endtask

   // long receiver hold-off while requests keep coming
   task automatic test_backpressure();
      fork
         begin
            hold_long = 1'b1;
            repeat (2000) @(posedge clock);
            hold_long = 1'b0;
         end
         begin
            send_message(2, 5);
            send_message(0, 8);
            send_message(1, 2);
         end
      join
   endtask

   // random messages, mostly short, a few long
   task automatic test_random();
      int nfull;
      while (sent < 220) begin
         nfull = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 6);
         send_message(nfull, $urandom_range(0, 15));
      end
   endtask

   initial begin
      hold_long = 1'b0;
      mismatches = 0;
      checked = 0;
      sent = 0;
      messages = 0;
      cycle_count = 0;
      req.valid <= 1'b0;
      req.message_word <= '0;
      req.byte_count <= '0;
      req.final_item <= 1'b0;
      reset <= 1'b1;
      hash_restart();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random();
      req.valid <= 1'b0;
      while (digest_queue.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("%0d requests in %0d messages sent, %0d digest words checked",
         sent, messages, checked);
      if (mismatches == 0) $display("SCOREBOARD CLEAN");
      else begin
         $display("%0d mismatches", mismatches);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
